[rtl/tfcl_pkg.sv]
// shared types and constants for the three-level fifo cache lookup
package tfcl_pkg;

    localparam int LAT_W   = 8;
    localparam int MEM_W   = 10;
    localparam int TOT_W   = 11;
    localparam int CNT_W   = 32;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 10;

    localparam logic [CFG_A_W-1:0] REG_FIRST_LAT  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_SECOND_LAT = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_THIRD_LAT  = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_MEMORY_LAT = 2'd3;

    localparam logic [1:0] HIT_FIRST  = 2'd0;
    localparam logic [1:0] HIT_SECOND = 2'd1;
    localparam logic [1:0] HIT_THIRD  = 2'd2;
    localparam logic [1:0] HIT_MEMORY = 2'd3;

    localparam logic [LAT_W-1:0] RESET_FIRST_LAT  = 8'd4;
    localparam logic [LAT_W-1:0] RESET_SECOND_LAT = 8'd12;
    localparam logic [LAT_W-1:0] RESET_THIRD_LAT  = 8'd40;
    localparam logic [MEM_W-1:0] RESET_MEMORY_LAT = 10'd200;

    typedef struct packed {
        logic done;
        logic held;
    } t_lvl_sts;

endpackage

[rtl/tfcl_level.sv]
// one fully associative fifo cache level: tag memory, tag walk and fifo insert
module tfcl_level #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_commit,
    input  logic [ADDR_W-1:0]   i_addr,
    output tfcl_pkg::t_lvl_sts  o_sts
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);
    localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [FW-1:0]      r_fill, n_fill;
    logic [IW-1:0]      r_oldest, n_oldest;
    logic [FW-1:0]      r_idx, n_idx;
    logic               r_cmp_v, n_cmp_v;
    logic               r_held, n_held;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_rd;
    logic [ADDR_W-1:0]  mem [DEPTH];
    logic               wr_en;
    logic [IW-1:0]      wr_idx;
    logic               more;

    assign more = (r_idx < r_fill);

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_oldest = r_oldest;
        n_idx    = r_idx;
        n_cmp_v  = r_cmp_v;
        n_held   = r_held;
        wr_en    = 1'b0;
        wr_idx   = r_oldest;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_WALK;
                    n_idx   = '0;
                    n_cmp_v = 1'b0;
                    n_held  = 1'b0;
                end
            end
            S_WALK: begin
                n_cmp_v = more;
                if (more) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_cmp_v && (r_rd == r_addr)) begin
                    n_held = 1'b1;
                end
                if (!more && !r_cmp_v) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_commit) begin
                    n_state = S_IDLE;
                    if (!r_held) begin
                        wr_en = 1'b1;
                        if (r_fill < FILL_MAX) begin
                            wr_idx = r_fill[IW-1:0];
                            n_fill = r_fill + 1'b1;
                        end else begin
                            n_oldest = (r_oldest == IDX_LAST) ? '0 : r_oldest + 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_oldest <= '0;
            r_idx    <= '0;
            r_cmp_v  <= 1'b0;
            r_held   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_oldest <= n_oldest;
            r_idx    <= n_idx;
            r_cmp_v  <= n_cmp_v;
            r_held   <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_addr <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= r_addr;
        end
        r_rd <= mem[r_idx[IW-1:0]];
    end

    assign o_sts.done = (r_state == S_DONE);
    assign o_sts.held = r_held;

endmodule

[rtl/three_level_fifo_cache_lookup.sv]
// top level of the three-level fifo cache lookup: control, registers, result
// Each block address is looked up in three fully associative FIFO levels. All
// three tag memories are walked in parallel, one entry per cycle, each through
// its single read port, and the lookup of an item ends once the longest walk,
// over the filled entries of its level, is through. Items are handled one at a
// time; a finished result sits in an output register while the next item is
// already taken in. After reset all levels are empty and no clearing pass is
// needed.
module three_level_fifo_cache_lookup #(
    parameter int FIRST_DEPTH  = 32,
    parameter int SECOND_DEPTH = 128,
    parameter int THIRD_DEPTH  = 512,
    parameter int ADDRESS_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ADDRESS_BITS-1:0]       i_block_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_hit_level,
    output logic [tfcl_pkg::TOT_W-1:0]    o_total_latency,
    output logic [tfcl_pkg::CNT_W-1:0]    o_memory_access_total,
    input  logic                          i_cfg_we,
    input  logic [tfcl_pkg::CFG_A_W-1:0]  i_cfg_index,
    input  logic [tfcl_pkg::CFG_D_W-1:0]  i_cfg_data
);

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_WALK = 2'b10
    } t_state;

    t_state                      r_state;
    logic [tfcl_pkg::LAT_W-1:0]  r_lat1, r_lat2, r_lat3;
    logic [tfcl_pkg::MEM_W-1:0]  r_latm;
    logic [tfcl_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_out_v;
    logic [1:0]                  r_out_level;
    logic [tfcl_pkg::TOT_W-1:0]  r_out_tot;
    tfcl_pkg::t_lvl_sts          sts1, sts2, sts3;
    logic                        start, commit, all_done;
    logic [1:0]                  level;
    logic [tfcl_pkg::TOT_W-1:0]  total;

    assign o_in_ready = (r_state == T_IDLE);
    assign start      = i_in_valid && o_in_ready;
    assign all_done   = sts1.done && sts2.done && sts3.done;
    assign commit     = (r_state == T_WALK) && all_done && (!r_out_v || i_out_ready);

    tfcl_level #(.DEPTH(FIRST_DEPTH), .ADDR_W(ADDRESS_BITS)) u_first (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_commit(commit),
        .i_addr(i_block_address), .o_sts(sts1)
    );
    tfcl_level #(.DEPTH(SECOND_DEPTH), .ADDR_W(ADDRESS_BITS)) u_second (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_commit(commit),
        .i_addr(i_block_address), .o_sts(sts2)
    );
    tfcl_level #(.DEPTH(THIRD_DEPTH), .ADDR_W(ADDRESS_BITS)) u_third (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_commit(commit),
        .i_addr(i_block_address), .o_sts(sts3)
    );

    always_comb begin
        total = tfcl_pkg::TOT_W'(r_lat1);
        if (sts1.held) begin
            level = tfcl_pkg::HIT_FIRST;
        end else if (sts2.held) begin
            level = tfcl_pkg::HIT_SECOND;
            total = total + tfcl_pkg::TOT_W'(r_lat2);
        end else if (sts3.held) begin
            level = tfcl_pkg::HIT_THIRD;
            total = total + tfcl_pkg::TOT_W'(r_lat2) + tfcl_pkg::TOT_W'(r_lat3);
        end else begin
            level = tfcl_pkg::HIT_MEMORY;
            total = total + tfcl_pkg::TOT_W'(r_lat2) + tfcl_pkg::TOT_W'(r_lat3)
                  + tfcl_pkg::TOT_W'(r_latm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
            r_lat1  <= tfcl_pkg::RESET_FIRST_LAT;
            r_lat2  <= tfcl_pkg::RESET_SECOND_LAT;
            r_lat3  <= tfcl_pkg::RESET_THIRD_LAT;
            r_latm  <= tfcl_pkg::RESET_MEMORY_LAT;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tfcl_pkg::REG_FIRST_LAT:  r_lat1 <= i_cfg_data[tfcl_pkg::LAT_W-1:0];
                    tfcl_pkg::REG_SECOND_LAT: r_lat2 <= i_cfg_data[tfcl_pkg::LAT_W-1:0];
                    tfcl_pkg::REG_THIRD_LAT:  r_lat3 <= i_cfg_data[tfcl_pkg::LAT_W-1:0];
                    tfcl_pkg::REG_MEMORY_LAT: r_latm <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                T_IDLE: begin
                    if (start) begin
                        r_state <= T_WALK;
                    end
                end
                T_WALK: begin
                    if (commit) begin
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
            if (commit) begin
                r_out_v <= 1'b1;
                if (level == tfcl_pkg::HIT_MEMORY) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_level <= level;
            r_out_tot   <= total;
        end
    end

    assign o_out_valid           = r_out_v;
    assign o_hit_level           = r_out_level;
    assign o_total_latency       = r_out_tot;
    assign o_memory_access_total = r_cnt;

`ifndef ASSERT_OFF
    a_commit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (sts1.done && sts2.done && sts3.done))
        else $error("commit before all tag walks finished");
    a_count_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != $past(r_cnt)) |-> (r_out_v && r_out_level == tfcl_pkg::HIT_MEMORY))
        else $error("miss counter moved without a full miss");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (!r_out_v || i_out_ready))
        else $error("pending result overwritten");
`endif

endmodule
